// ----- hw/rtl/ctsu_pkg.sv -----
// ctsu_pkg: shared constants, codes, types and helpers of the tuple stepper
// used by ctsu_divider, ctsu_emit and cartesian_tuple_stepper_unit
`default_nettype none

package ctsu_pkg;

    localparam int MAX_GROUPS  = 8;
    localparam int DIGIT_BITS  = 8;
    localparam int RANK_BITS   = 64;
    localparam int GROUP_BITS  = $clog2(MAX_GROUPS);
    localparam int COUNT_BITS  = 4;
    localparam int OFFSET_BITS = 11;
    localparam int STATUS_BITS = 2;
    localparam int OPCODE_BITS = 2;
    localparam int LENGTHS_BITS = MAX_GROUPS * DIGIT_BITS;
    localparam int CFG_BITS    = LENGTHS_BITS;
    localparam int INDEX_BITS  = 1;
    localparam int DIVISOR_BITS = DIGIT_BITS + 1;
    localparam int ITER_BITS   = $clog2(RANK_BITS);

    typedef logic [DIGIT_BITS-1:0]   digit_t;
    typedef logic [RANK_BITS-1:0]    rank_t;
    typedef logic [GROUP_BITS-1:0]   group_t;
    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [OFFSET_BITS-1:0]  offset_t;
    typedef logic [STATUS_BITS-1:0]  status_t;
    typedef logic [OPCODE_BITS-1:0]  opcode_t;
    typedef logic [LENGTHS_BITS-1:0] lengths_t;
    typedef logic [CFG_BITS-1:0]     cfg_data_t;
    typedef logic [INDEX_BITS-1:0]   cfg_index_t;
    typedef logic [DIVISOR_BITS-1:0] divisor_t;

    localparam opcode_t OP_SEEK = 2'd0;
    localparam opcode_t OP_NEXT = 2'd1;
    localparam opcode_t OP_PREV = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_WRAP  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    localparam cfg_index_t REG_GROUP_COUNT   = 1'b0;
    localparam cfg_index_t REG_GROUP_LENGTHS = 1'b1;

    typedef struct packed {
        logic    valid;
        group_t  pos;
        digit_t  digit;
        count_t  mult;
        status_t status;
        logic    last;
    } emit_req_t;

    function automatic digit_t max_digit(input lengths_t lengths, input group_t g);
        max_digit = lengths[g*DIGIT_BITS +: DIGIT_BITS];
    endfunction

    function automatic count_t active_groups(input count_t cnt);
        if (cnt == '0)
            active_groups = count_t'(1);
        else if (cnt > count_t'(MAX_GROUPS))
            active_groups = count_t'(MAX_GROUPS);
        else
            active_groups = cnt;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ctsu_divider.sv -----
// ctsu_divider: bit-serial restoring divider, one quotient bit per cycle
// depends on ctsu_pkg
`default_nettype none

module ctsu_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire ctsu_pkg::rank_t   dividend,
    input  wire ctsu_pkg::divisor_t divisor,
    output logic                   done,
    output ctsu_pkg::rank_t        quotient,
    output ctsu_pkg::digit_t       remainder
);
    import ctsu_pkg::*;

    logic                 active_reg;
    logic                 done_reg;
    logic [ITER_BITS-1:0] iter_reg;
    rank_t                quot_reg;
    digit_t               rem_reg;
    divisor_t             div_reg;
    divisor_t             shifted;
    logic                 fits;

    assign shifted = {rem_reg, quot_reg[RANK_BITS-1]};
    assign fits    = (shifted >= div_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            iter_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                active_reg <= 1'b1;
                iter_reg   <= '0;
            end
            else if (active_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_BITS'(RANK_BITS - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (active_reg)
        begin
            quot_reg <= {quot_reg[RANK_BITS-2:0], fits};
            rem_reg  <= fits ? DIGIT_BITS'(shifted - div_reg) : DIGIT_BITS'(shifted);
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ctsu_emit.sv -----
// ctsu_emit: result register, scales one digit by the group count per result
// depends on ctsu_pkg
`default_nettype none

module ctsu_emit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctsu_pkg::emit_req_t req,
    output logic                     strobe,
    output ctsu_pkg::group_t         group_position,
    output ctsu_pkg::offset_t        element_offset,
    output ctsu_pkg::status_t        status,
    output logic                     last
);
    import ctsu_pkg::*;

    localparam int PROD_BITS = DIGIT_BITS + COUNT_BITS;

    logic                 strobe_reg;
    group_t               pos_reg;
    offset_t              offset_reg;
    status_t              status_reg;
    logic                 last_reg;
    logic [PROD_BITS-1:0] prod;

    assign prod = PROD_BITS'(req.digit) * PROD_BITS'(req.mult);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            pos_reg    <= req.pos;
            offset_reg <= prod[OFFSET_BITS-1:0];
            status_reg <= req.status;
            last_reg   <= req.last;
        end
    end

    assign strobe         = strobe_reg;
    assign group_position = pos_reg;
    assign element_offset = offset_reg;
    assign status         = status_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cartesian_tuple_stepper_unit.sv -----
// cartesian_tuple_stepper_unit: top level, digit store, sequencer and config registers
// depends on ctsu_pkg, ctsu_divider and ctsu_emit
`default_nettype none

// usage:
// an item is taken when start is high and busy is low; opcode selects seek,
// next or prev, rank is used by seek only. config registers are written through
// wr_en / wr_index / wr_data, by the user only while busy is low: not enforced.
// each item returns one result per active group, group 0 first, each shown on
// the result ports for one cycle with strobe high; last marks the final group.
// next / prev: carry or borrow from the last group toward group 0, one group per
// cycle, then one result per group; busy drops as the last result enters the
// output register.
// seek: one bit-serial division per group, last group first, then the results;
// the divider sets the seek time.
// opcode 3: held digits are emitted unchanged; one item is worked at a time.
// reset: digits all zero, group count 1, all length fields 0, no result pending.
// results cannot be held off: the receiver must take each one as it appears.

module cartesian_tuple_stepper_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire ctsu_pkg::opcode_t    opcode,
    input  wire ctsu_pkg::rank_t      rank,
    input  wire logic                 wr_en,
    input  wire ctsu_pkg::cfg_index_t wr_index,
    input  wire ctsu_pkg::cfg_data_t  wr_data,
    output logic                      strobe,
    output ctsu_pkg::group_t          group_position,
    output ctsu_pkg::offset_t         element_offset,
    output ctsu_pkg::status_t         status,
    output logic                      last
);
    import ctsu_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SEEK_GO   = 3'd1;
    localparam logic [2:0] S_SEEK_WAIT = 3'd2;
    localparam logic [2:0] S_STEP      = 3'd3;
    localparam logic [2:0] S_EMIT      = 3'd4;

    logic [2:0] state_reg,  state_next;
    count_t     count_reg;
    lengths_t   lengths_reg;
    digit_t     digits_reg [MAX_GROUPS];
    digit_t     digits_next [MAX_GROUPS];
    count_t     m_reg,      m_next;
    group_t     grp_reg,    grp_next;
    group_t     idx_reg,    idx_next;
    opcode_t    op_reg,     op_next;
    status_t    stat_reg,   stat_next;
    rank_t      rank_reg,   rank_next;

    logic       div_go;
    logic       div_done;
    rank_t      div_quot;
    digit_t     div_rem;
    divisor_t   divisor;
    digit_t     cur_digit;
    digit_t     cur_max;
    group_t     last_grp;
    emit_req_t  req;

    assign cur_digit = digits_reg[grp_reg];
    assign cur_max   = max_digit(lengths_reg, grp_reg);
    assign divisor   = DIVISOR_BITS'(cur_max) + 1'b1;
    assign last_grp  = GROUP_BITS'(m_reg - 1'b1);
    assign busy      = (state_reg != S_IDLE);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= count_t'(1);
            lengths_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_GROUP_COUNT:   count_reg   <= wr_data[COUNT_BITS-1:0];
                REG_GROUP_LENGTHS: lengths_reg <= wr_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        m_next      = m_reg;
        grp_next    = grp_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        stat_next   = stat_reg;
        rank_next   = rank_reg;
        div_go      = 1'b0;
        req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    m_next    = active_groups(count_reg);
                    grp_next  = GROUP_BITS'(active_groups(count_reg) - 1'b1);
                    idx_next  = '0;
                    op_next   = opcode;
                    stat_next = ST_OK;
                    rank_next = rank;
                    case (opcode)
                        OP_SEEK:
                        begin
                            for (int g = 0; g < MAX_GROUPS; g++)
                                digits_next[g] = '0;
                            state_next = S_SEEK_GO;
                        end
                        OP_NEXT, OP_PREV: state_next = S_STEP;
                        default:          state_next = S_EMIT;
                    endcase
                end
            end
            S_SEEK_GO:
            begin
                div_go     = 1'b1;
                state_next = S_SEEK_WAIT;
            end
            S_SEEK_WAIT:
            begin
                if (div_done)
                begin
                    digits_next[grp_reg] = div_rem;
                    rank_next            = div_quot;
                    if (grp_reg == '0)
                    begin
                        if (div_quot != '0)
                        begin
                            stat_next = ST_RANGE;
                            for (int g = 0; g < MAX_GROUPS; g++)
                                digits_next[g] = '0;
                        end
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        grp_next   = grp_reg - 1'b1;
                        state_next = S_SEEK_GO;
                    end
                end
            end
            S_STEP:
            begin
                if (op_reg == OP_NEXT)
                begin
                    if (cur_digit < cur_max)
                    begin
                        digits_next[grp_reg] = cur_digit + 1'b1;
                        state_next           = S_EMIT;
                    end
                    else
                    begin
                        digits_next[grp_reg] = '0;
                        if (grp_reg == '0)
                        begin
                            stat_next  = ST_WRAP;
                            state_next = S_EMIT;
                        end
                        else
                            grp_next = grp_reg - 1'b1;
                    end
                end
                else
                begin
                    if (cur_digit != '0)
                    begin
                        digits_next[grp_reg] = cur_digit - 1'b1;
                        state_next           = S_EMIT;
                    end
                    else
                    begin
                        digits_next[grp_reg] = cur_max;
                        if (grp_reg == '0)
                        begin
                            stat_next  = ST_WRAP;
                            state_next = S_EMIT;
                        end
                        else
                            grp_next = grp_reg - 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                req.valid  = 1'b1;
                req.pos    = idx_reg;
                req.digit  = digits_reg[idx_reg];
                req.mult   = m_reg;
                req.status = stat_reg;
                req.last   = (idx_reg == last_grp);
                if (idx_reg == last_grp)
                    state_next = S_IDLE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int g = 0; g < MAX_GROUPS; g++)
                digits_reg[g] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            digits_reg <= digits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        grp_reg  <= grp_next;
        idx_reg  <= idx_next;
        op_reg   <= op_next;
        stat_reg <= stat_next;
        rank_reg <= rank_next;
    end

    ctsu_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (rank_reg),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    ctsu_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .strobe         (strobe),
        .group_position (group_position),
        .element_offset (element_offset),
        .status         (status),
        .last           (last)
    );

endmodule

`default_nettype wire

// ----- dv/tb_cartesian_tuple_stepper_unit.sv -----
// tb_cartesian_tuple_stepper_unit: self-checking testbench for the tuple stepper
// predicts every result of seek, next, prev and hold items and checks them in order
// depends on ctsu_pkg and cartesian_tuple_stepper_unit
`default_nettype none

module tb_cartesian_tuple_stepper_unit;

    import ctsu_pkg::*;

    localparam opcode_t OP_HOLD      = 2'd3;
    localparam int      CYCLE_LIMIT  = 1500000;
    localparam int      DRAIN_LIMIT  = 20000;
    localparam int      SETTLE_CYCLES = 600;

    typedef struct {
        group_t  pos;
        offset_t offset;
        status_t st;
        logic    last;
    } tuple_result_t;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       start    = 1'b0;
    opcode_t    opcode   = OP_SEEK;
    rank_t      rank     = '0;
    logic       wr_en    = 1'b0;
    cfg_index_t wr_index = REG_GROUP_COUNT;
    cfg_data_t  wr_data  = '0;
    logic       busy;
    logic       strobe;
    group_t     group_position;
    offset_t    element_offset;
    status_t    status;
    logic       last;

    count_t   cfg_count   = count_t'(1);
    lengths_t cfg_lengths = '0;
    digit_t   tuple_digits [MAX_GROUPS];
    tuple_result_t tuple_results [$];
    int       fail_count  = 0;
    bit       idle_on     = 1'b1;

    cartesian_tuple_stepper_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .rank           (rank),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .strobe         (strobe),
        .group_position (group_position),
        .element_offset (element_offset),
        .status         (status),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    function automatic count_t groups_active();
        if (cfg_count == '0)
            return count_t'(1);
        else if (cfg_count > count_t'(MAX_GROUPS))
            return count_t'(MAX_GROUPS);
        return cfg_count;
    endfunction

    task automatic step_tuple(input opcode_t op, input rank_t rk);
        count_t        m;
        status_t       st;
        digit_t        quot_digits [MAX_GROUPS];
        digit_t        top;
        logic [127:0]  rem;
        logic [8:0]    radix;
        bit            done;
        int            g;
        tuple_result_t res;
        m = groups_active();
        st = ST_OK;
        done = 1'b0;
        case (op)
            OP_SEEK:
            begin
                rem = {64'd0, rk};
                for (g = int'(m) - 1; g >= 0; g--)
                begin
                    radix = {1'b0, cfg_lengths[g*DIGIT_BITS +: DIGIT_BITS]} + 9'd1;
                    quot_digits[g] = digit_t'(rem % radix);
                    rem = rem / radix;
                end
                if (rem != 0)
                    st = ST_RANGE;
                for (g = 0; g < MAX_GROUPS; g++)
                    tuple_digits[g] = (st == ST_OK && g < int'(m)) ? quot_digits[g] : '0;
            end
            OP_NEXT:
            begin
                st = ST_WRAP;
                for (g = int'(m) - 1; g >= 0; g--)
                begin
                    top = cfg_lengths[g*DIGIT_BITS +: DIGIT_BITS];
                    if (!done)
                    begin
                        if (tuple_digits[g] < top)
                        begin
                            tuple_digits[g] = tuple_digits[g] + 1'b1;
                            st = ST_OK;
                            done = 1'b1;
                        end
                        else
                            tuple_digits[g] = '0;
                    end
                end
            end
            OP_PREV:
            begin
                st = ST_WRAP;
                for (g = int'(m) - 1; g >= 0; g--)
                begin
                    top = cfg_lengths[g*DIGIT_BITS +: DIGIT_BITS];
                    if (!done)
                    begin
                        if (tuple_digits[g] != '0)
                        begin
                            tuple_digits[g] = tuple_digits[g] - 1'b1;
                            st = ST_OK;
                            done = 1'b1;
                        end
                        else
                            tuple_digits[g] = top;
                    end
                end
            end
            default:
                st = ST_OK;
        endcase
        for (g = 0; g < int'(m); g++)
        begin
            res.pos = group_t'(g);
            res.offset = offset_t'(int'(tuple_digits[g]) * int'(m));
            res.st = st;
            res.last = (g == int'(m) - 1);
            tuple_results.push_back(res);
        end
    endtask

    task automatic issue_item(input opcode_t op, input rank_t rk);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            opcode <= opcode_t'($urandom);
            rank <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        rank <= rk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        step_tuple(op, rk);
    endtask

    task automatic load_config(input cfg_data_t count_word, input lengths_t lengths);
        start <= 1'b0;
        @(posedge clk);
        while (tuple_results.size() != 0 || busy)
            @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= REG_GROUP_COUNT;
        wr_data <= count_word;
        @(posedge clk);
        wr_index <= REG_GROUP_LENGTHS;
        wr_data <= lengths;
        @(posedge clk);
        wr_en <= 1'b0;
        cfg_count = count_t'(count_word);
        cfg_lengths = lengths;
    endtask

    task automatic load_random_config(input int style);
        cfg_data_t count_word;
        lengths_t  lengths;
        int        g;
        count_word = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0)
            count_word[COUNT_BITS-1:0] = count_t'($urandom_range(0, 15));
        else
            count_word[COUNT_BITS-1:0] = count_t'($urandom_range(1, MAX_GROUPS));
        for (g = 0; g < MAX_GROUPS; g++)
        begin
            case (style)
                0: lengths[g*DIGIT_BITS +: DIGIT_BITS] = digit_t'($urandom_range(0, 3));
                1: lengths[g*DIGIT_BITS +: DIGIT_BITS] = digit_t'($urandom);
                2:
                begin
                    case ($urandom_range(0, 2))
                        0: lengths[g*DIGIT_BITS +: DIGIT_BITS] = '0;
                        1: lengths[g*DIGIT_BITS +: DIGIT_BITS] = '1;
                        default:
                            lengths[g*DIGIT_BITS +: DIGIT_BITS] = digit_t'($urandom_range(0, 5));
                    endcase
                end
                default: lengths[g*DIGIT_BITS +: DIGIT_BITS] = digit_t'($urandom_range(0, 15));
            endcase
        end
        load_config(count_word, lengths);
    endtask

    function automatic rank_t pick_seek_rank();
        logic [127:0] span;
        rank_t        raw;
        int           g;
        int           pick;
        span = 128'd1;
        for (g = 0; g < int'(groups_active()); g++)
            span = span * ({120'd0, cfg_lengths[g*DIGIT_BITS +: DIGIT_BITS]} + 128'd1);
        raw = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return rank_t'({64'd0, raw} % span);
        else if (pick == 6)
            return rank_t'(span - 128'd1);
        else if (pick == 7 && span[127:64] == '0)
            return rank_t'(span);
        return raw;
    endfunction

    task automatic run_random_phases(input int phases, input int per_phase);
        int      phase;
        int      sent;
        int      run;
        int      k;
        int      pick;
        opcode_t op;
        for (phase = 0; phase < phases; phase++)
        begin
            load_random_config(phase % 4);
            sent = 0;
            while (sent < per_phase)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    issue_item(OP_SEEK, pick_seek_rank());
                    sent++;
                end
                else if (pick < 20)
                begin
                    issue_item(OP_HOLD, {$urandom, $urandom});
                    sent++;
                end
                else
                begin
                    op = (pick < 60) ? OP_NEXT : OP_PREV;
                    run = $urandom_range(1, 12);
                    for (k = 0; k < run; k++)
                        issue_item(op, {$urandom, $urandom});
                    sent += run;
                end
            end
        end
    endtask

    task automatic test_reset_defaults();
        issue_item(OP_NEXT, '0);
        issue_item(OP_PREV, '1);
        issue_item(OP_SEEK, 64'd0);
        issue_item(OP_SEEK, 64'd1);
        issue_item(OP_HOLD, '0);
    endtask

    task automatic test_group_count_limits();
        // zero count acts as one group, junk above the count field
        load_config(64'hFFFF_FFFF_FFFF_FFF0, 64'h0706_0504_0302_0109);
        issue_item(OP_SEEK, 64'd5);
        // count above eight saturates
        load_config(64'h0000_0000_0000_000F, '1);
        issue_item(OP_SEEK, '1);
        issue_item(OP_NEXT, '0);
        issue_item(OP_PREV, '0);
        issue_item(OP_SEEK, 64'd0);
    endtask

    task automatic test_seek_bounds();
        load_config(64'd3, 64'h0000_0000_0006_0402);
        issue_item(OP_SEEK, 64'd104);
        issue_item(OP_NEXT, '1);
        issue_item(OP_SEEK, 64'd105);
        issue_item(OP_PREV, '0);
        issue_item(OP_SEEK, '1);
        issue_item(OP_SEEK, 64'd52);
        issue_item(OP_HOLD, '1);
    endtask

    task automatic test_digit_above_max();
        load_config(64'd2, 64'h0000_0000_0000_FFFF);
        issue_item(OP_SEEK, 64'hFFFE);
        // shrink the lengths under the held digits
        load_config(64'd2, 64'h0000_0000_0000_0303);
        issue_item(OP_PREV, '0);
        issue_item(OP_NEXT, '0);
        issue_item(OP_NEXT, '0);
    endtask

    task automatic test_random_walk();
        run_random_phases(8, 50);
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        run_random_phases(1, 40);
    endtask

    task automatic finish_run();
        int drain;
        start <= 1'b0;
        drain = 0;
        while (tuple_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tuple_results.size() != 0)
        begin
            $error("results missing: %0d still expected", tuple_results.size());
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        tuple_result_t want;
        if (rst_n && strobe)
        begin
            if (tuple_results.size() == 0)
            begin
                $error("unexpected result: group_position %0d element_offset %0d status %0d",
                       group_position, element_offset, status);
                fail_count++;
            end
            else
            begin
                want = tuple_results.pop_front();
                if (group_position !== want.pos)
                begin
                    $error("group_position: expected %0d, actual %0d", want.pos, group_position);
                    fail_count++;
                end
                if (element_offset !== want.offset)
                begin
                    $error("element_offset: expected %0d, actual %0d", want.offset,
                           element_offset);
                    fail_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        for (int g = 0; g < MAX_GROUPS; g++)
            tuple_digits[g] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_group_count_limits();
        test_seek_bounds();
        test_digit_above_max();
        test_random_walk();
        test_full_rate();
        finish_run();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/ctsu_pkg.sv
hw/rtl/ctsu_divider.sv
hw/rtl/ctsu_emit.sv
hw/rtl/cartesian_tuple_stepper_unit.sv
dv/tb_cartesian_tuple_stepper_unit.sv
